// ===== rtl/calendar_time_counter_defines.svh =====
// Assertion macros for the calendar time counter.
// No dependencies; included by modules that carry assertions.
`ifndef CALENDAR_TIME_COUNTER_DEFINES_SVH
`define CALENDAR_TIME_COUNTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define CTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ctc_pkg.sv =====
// Shared types, constants and calendar functions for the calendar time counter.
// No dependencies; imported by ctc_next and calendar_time_counter.
package ctc_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_TIME = 2'd1,
        OP_SET_DATE = 2'd2
    } t_ctc_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  new_hour;
        logic [6:0]  new_minute;
        logic [6:0]  new_second;
        logic [6:0]  new_day;
        logic [6:0]  new_month;
        logic [13:0] new_year;
    } t_ctc_in;

    typedef struct packed {
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [5:0]  second_now;
        logic [4:0]  day_now;
        logic [3:0]  month_now;
        logic [13:0] year_now;
        logic        set_rejected;
        logic        year_wrapped;
    } t_ctc_out;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_ctc_time;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [13:0] INV_25    = 14'd7209;
    localparam logic [13:0] DIV25_LIM = 14'd655;

    localparam t_ctc_time TIME_RESET = '{
        hour:   5'd14,
        minute: 6'd2,
        second: 6'd52,
        day:    5'd9,
        month:  4'd6,
        year:   14'd2024
    };

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // divisibility by 25 via the modular inverse of 25 mod 2^14
    function automatic logic f_div25(input logic [13:0] y);
        logic [27:0] prod;
        prod = 28'(y) * 28'(INV_25);
        return prod[13:0] <= DIV25_LIM;
    endfunction

    function automatic logic f_leap(input logic [13:0] y);
        logic d25;
        d25 = f_div25(y);
        return ((y[1:0] == 2'd0) && !d25) || ((y[3:0] == 4'd0) && d25);
    endfunction

    function automatic logic [4:0] f_days_in(input logic [6:0] m, input logic [13:0] y);
        logic [3:0] idx;
        idx = m[3:0] - 4'd1;
        if (m < 7'd1 || m > 7'd12) begin
            return 5'd0;
        end
        if (m == 7'd2 && f_leap(y)) begin
            return 5'd29;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage

// ===== rtl/calendar_time_counter.sv =====
// Top level of the calendar time counter: input register, time state, result register.
// Depends on ctc_pkg, ctc_next and calendar_time_counter_defines.svh.
//
// Real-time clock with Gregorian calendar. Each item is a one-second tick, a set-time
// or a set-date; each returns one result with the full time and date after the item,
// a reject flag for invalid set values and a flag for the wrap from year 9999 to 0.
// An item passes an input register, then one combinational pass through ctc_next that
// updates the time state and loads the result register at the same edge. One item is
// accepted every cycle, and input stalls only when the input register is full and the
// result register is held by downstream stall. After reset the clock reads 14:02:52
// on 9 June 2024.
module calendar_time_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ctc_pkg::t_ctc_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ctc_pkg::t_ctc_out o_out_item
);
    import ctc_pkg::*;
    `include "calendar_time_counter_defines.svh"

    logic      r_in_v;
    t_ctc_in   r_in;
    t_ctc_time r_time;
    logic      r_out_v;
    t_ctc_out  r_out;

    t_ctc_time n_time;
    logic      n_rejected;
    logic      n_wrapped;
    logic      advance;

    ctc_next u_next (
        .i_time     (r_time),
        .i_item     (r_in),
        .o_time     (n_time),
        .o_rejected (n_rejected),
        .o_wrapped  (n_wrapped)
    );

    assign o_in_stall = r_in_v && r_out_v && i_out_stall;
    assign advance    = r_in_v && !(r_out_v && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_time  <= TIME_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_v <= i_in_valid;
                if (i_in_valid) begin
                    r_in <= i_in_item;
                end
            end
            if (advance) begin
                r_out_v <= 1'b1;
                r_time  <= n_time;
                r_out   <= '{
                    hour_now:     n_time.hour,
                    minute_now:   n_time.minute,
                    second_now:   n_time.second,
                    day_now:      n_time.day,
                    month_now:    n_time.month,
                    year_now:     n_time.year,
                    set_rejected: n_rejected,
                    year_wrapped: n_wrapped
                };
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    `CTC_ASSERT_IMP(a_time_range, i_clk, i_rst_n, 1'b1,
        r_time.second < 6'd60 && r_time.minute < 6'd60 && r_time.hour < 5'd24)
    `CTC_ASSERT_IMP(a_date_range, i_clk, i_rst_n, 1'b1,
        r_time.day != 5'd0 && r_time.day <= f_days_in({3'd0, r_time.month}, r_time.year)
        && r_time.year <= YEAR_MAX)
    `CTC_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, o_out_valid,
        !(o_out_item.set_rejected && o_out_item.year_wrapped))
    `CTC_ASSERT_IMP(a_wrap_value, i_clk, i_rst_n, o_out_valid && o_out_item.year_wrapped,
        o_out_item.year_now == 14'd0 && o_out_item.month_now == 4'd1
        && o_out_item.day_now == 5'd1 && o_out_item.hour_now == 5'd0)
    `CTC_ASSERT_NXT(a_reject_hold, i_clk, i_rst_n, advance && n_rejected,
        r_time == $past(r_time))

endmodule

// ===== rtl/ctc_next.sv =====
// Next-state logic of the calendar time counter: tick carry chain and set checks.
// Depends on ctc_pkg.
module ctc_next (
    input  ctc_pkg::t_ctc_time i_time,
    input  ctc_pkg::t_ctc_in   i_item,
    output ctc_pkg::t_ctc_time o_time,
    output logic               o_rejected,
    output logic               o_wrapped
);
    import ctc_pkg::*;

    logic [4:0] cur_days;
    logic [4:0] new_days;

    assign cur_days = f_days_in({3'd0, i_time.month}, i_time.year);
    assign new_days = f_days_in(i_item.new_month, i_item.new_year);

    always_comb begin
        o_time     = i_time;
        o_rejected = 1'b0;
        o_wrapped  = 1'b0;
        unique case (t_ctc_op'(i_item.operation))
            OP_TICK: begin
                if (i_time.second < 6'd59) begin
                    o_time.second = i_time.second + 6'd1;
                end else begin
                    o_time.second = 6'd0;
                    if (i_time.minute < 6'd59) begin
                        o_time.minute = i_time.minute + 6'd1;
                    end else begin
                        o_time.minute = 6'd0;
                        if (i_time.hour < 5'd23) begin
                            o_time.hour = i_time.hour + 5'd1;
                        end else begin
                            o_time.hour = 5'd0;
                            if (i_time.day < cur_days) begin
                                o_time.day = i_time.day + 5'd1;
                            end else begin
                                o_time.day = 5'd1;
                                if (i_time.month < 4'd12) begin
                                    o_time.month = i_time.month + 4'd1;
                                end else begin
                                    o_time.month = 4'd1;
                                    if (i_time.year >= YEAR_MAX) begin
                                        o_time.year = 14'd0;
                                        o_wrapped   = 1'b1;
                                    end else begin
                                        o_time.year = i_time.year + 14'd1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            OP_SET_TIME: begin
                if (i_item.new_hour < 7'd24 && i_item.new_minute < 7'd60
                        && i_item.new_second < 7'd60) begin
                    o_time.hour   = i_item.new_hour[4:0];
                    o_time.minute = i_item.new_minute[5:0];
                    o_time.second = i_item.new_second[5:0];
                end else begin
                    o_rejected = 1'b1;
                end
            end
            OP_SET_DATE: begin
                if (i_item.new_year <= YEAR_MAX && i_item.new_day != 7'd0
                        && i_item.new_day <= {2'd0, new_days}) begin
                    o_time.day   = i_item.new_day[4:0];
                    o_time.month = i_item.new_month[3:0];
                    o_time.year  = i_item.new_year;
                end else begin
                    o_rejected = 1'b1;
                end
            end
            default: begin
                o_time = i_time;
            end
        endcase
    end

endmodule
